// ===== hw/rtl/fmh_pkg.sv =====
// shared types, constants and helper functions of the four-lane multiply hash
`timescale 1ns / 1ps
`default_nettype none

package fmh_pkg;

  // width of the length field on the input port
  localparam int LEN_PORT_W = 32;

  // entries in the command queue between front and back
  localparam int Q_DEPTH = 2;

  // mix_mode register codes
  localparam logic [1:0] MODE_PLAIN      = 2'd0;
  localparam logic [1:0] MODE_FOLD_ALL   = 2'd1;
  localparam logic [1:0] MODE_FOLD_FINAL = 2'd2;

  // multiplier constant select
  typedef enum logic [1:0] {
    K_0 = 2'd0,
    K_1 = 2'd1,
    K_2 = 2'd2,
    K_3 = 2'd3
  } kc_t;

  // command passed from the front to the back
  typedef struct packed {
    logic                  is_start;
    logic                  last;
    logic [1:0]            lane;
    logic [63:0]           data;
    logic [LEN_PORT_W-1:0] len;
  } cmd_t;

  // multiplier constant lookup
  function automatic logic [63:0] k_const(input kc_t sel);
    logic [63:0] k;
    unique case (sel)
      K_0:     k = 64'h9E37_79B9_7F4A_7C15;
      K_1:     k = 64'h85EB_CA77_C2B2_AE3D;
      K_2:     k = 64'hBF58_476D_1CE4_E5B9;
      K_3:     k = 64'h94D0_49BB_1331_11EB;
      default: k = 64'h9E37_79B9_7F4A_7C15;
    endcase
    return k;
  endfunction

  // per-lane rotate left by 11, 19, 35 or 47
  function automatic logic [63:0] rot_lane(input logic [63:0] w, input logic [1:0] lane);
    logic [63:0] r;
    unique case (lane)
      2'd0:    r = {w[52:0], w[63:53]};
      2'd1:    r = {w[44:0], w[63:45]};
      2'd2:    r = {w[28:0], w[63:29]};
      2'd3:    r = {w[16:0], w[63:17]};
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fmh_front.sv =====
// front end: takes requests, tracks message position, builds lane commands
`timescale 1ns / 1ps
`default_nettype none

module fmh_front #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic                          in_first,
  input  wire logic [63:0]                   in_seed,
  input  wire logic [fmh_pkg::LEN_PORT_W-1:0] in_total_length,
  input  wire logic [63:0]                   in_data_word,
  input  wire logic                          q_full,
  output      logic                          push,
  output      fmh_pkg::cmd_t                 cmd
);

  localparam int LEN_W = (LENGTH_BITS < fmh_pkg::LEN_PORT_W) ? LENGTH_BITS : fmh_pkg::LEN_PORT_W;

  logic             in_msg_r, in_msg_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] taken_r, taken_nxt;

  logic             accept;
  logic [LEN_W-1:0] len_in;
  logic [LEN_W-1:0] rem;
  logic [LEN_W-1:0] block_end;
  logic             short_word;
  logic [LEN_W-1:0] step_bytes;
  logic [LEN_W-1:0] taken_add;
  logic [1:0]       lane;
  logic [63:0]      word_m;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign len_in   = in_total_length[LEN_W-1:0];

  // position within the message
  assign rem        = len_r - taken_r;
  assign block_end  = {len_r[LEN_W-1:5], 5'b0};
  assign short_word = rem < LEN_W'(8);
  assign step_bytes = short_word ? rem : LEN_W'(8);
  assign taken_add  = taken_r + step_bytes;
  assign lane       = (taken_r < block_end) ? taken_r[4:3] : 2'd0;

  // zero the bytes past the end of the message
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (short_word && (3'(i) >= rem[2:0])) begin
        word_m[8*i +: 8] = 8'h00;
      end else begin
        word_m[8*i +: 8] = in_data_word[8*i +: 8];
      end
    end
  end

  // command build and position update
  always_comb begin
    push       = 1'b0;
    cmd        = '0;
    in_msg_nxt = in_msg_r;
    len_nxt    = len_r;
    taken_nxt  = taken_r;
    if (accept) begin
      if (in_first) begin
        push         = 1'b1;
        cmd.is_start = 1'b1;
        cmd.last     = (len_in == '0);
        cmd.data     = in_seed;
        cmd.len      = fmh_pkg::LEN_PORT_W'(len_in);
        len_nxt      = len_in;
        taken_nxt    = '0;
        in_msg_nxt   = (len_in != '0);
      end else if (in_msg_r) begin
        push         = 1'b1;
        cmd.is_start = 1'b0;
        cmd.last     = (taken_add >= len_r);
        cmd.lane     = lane;
        cmd.data     = fmh_pkg::rot_lane(word_m, lane);
        taken_nxt    = taken_add;
        in_msg_nxt   = (taken_add < len_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
      len_r    <= '0;
      taken_r  <= '0;
    end else begin
      in_msg_r <= in_msg_nxt;
      len_r    <= len_nxt;
      taken_r  <= taken_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fmh_queue.sv =====
// short command queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module fmh_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire fmh_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output      logic          q_valid,
  output      logic          q_full,
  output      fmh_pkg::cmd_t head
);

  localparam int PTR_W = (fmh_pkg::Q_DEPTH > 1) ? $clog2(fmh_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(fmh_pkg::Q_DEPTH + 1);

  fmh_pkg::cmd_t    mem_r [fmh_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_valid = (cnt_r != '0);
  assign q_full  = (cnt_r == CNT_W'(fmh_pkg::Q_DEPTH));
  assign head    = mem_r[rd_r];

  // pointer wrap
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(fmh_pkg::Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // pointer and count update
  always_comb begin
    wr_nxt  = push ? ptr_inc(wr_r) : wr_r;
    rd_nxt  = pop ? ptr_inc(rd_r) : rd_r;
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fmh_mul.sv =====
// two-stage 64x64 multiplier: 32x32 partial products, then low half or high^low fold
`timescale 1ns / 1ps
`default_nettype none

module fmh_mul (
  input  wire logic         clk,
  input  wire logic [63:0]  a,
  input  wire fmh_pkg::kc_t k_sel,
  input  wire logic         fold,
  output      logic [63:0]  r
);

  logic [63:0] k;
  logic [63:0] p00_r, p01_r, p10_r, p11_r;
  logic [63:0] p00_nxt, p01_nxt, p10_nxt, p11_nxt;
  logic        fold_r;
  logic [33:0] mid;
  logic [63:0] lo;
  logic [63:0] hi;

  assign k = fmh_pkg::k_const(k_sel);

  // partial products
  always_comb begin
    p00_nxt = a[31:0]  * k[31:0];
    p01_nxt = a[31:0]  * k[63:32];
    p10_nxt = a[63:32] * k[31:0];
    p11_nxt = a[63:32] * k[63:32];
  end

  always_ff @(posedge clk) begin
    p00_r  <= p00_nxt;
    p01_r  <= p01_nxt;
    p10_r  <= p10_nxt;
    p11_r  <= p11_nxt;
    fold_r <= fold;
  end

  // sum partial products into the 64-bit halves of the 128-bit product
  always_comb begin
    mid = {2'b0, p00_r[63:32]} + {2'b0, p01_r[31:0]} + {2'b0, p10_r[31:0]};
    lo  = {mid[31:0], p00_r[31:0]};
    hi  = p11_r + {32'b0, p01_r[63:32]} + {32'b0, p10_r[63:32]} + {62'b0, mid[33:32]};
    r   = fold_r ? (lo ^ hi) : lo;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fmh_back.sv =====
// back end: lane state, seeding, word absorb and finalizer around one shared multiplier
`timescale 1ns / 1ps
`default_nettype none

module fmh_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [1:0]    mode,
  input  wire logic          q_valid,
  input  wire fmh_pkg::cmd_t head,
  output      logic          pop,
  output      logic          out_valid,
  input  wire logic          out_ready,
  output      logic [63:0]   out_hash_value
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_WB   = 5'b00100,
    S_FOLD = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    SEQ_START = 2'd0,
    SEQ_WORD  = 2'd1,
    SEQ_FINAL = 2'd2
  } seq_t;

  state_t      state_r, state_nxt;
  seq_t        seq_r, seq_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] data_r, data_nxt;
  logic [fmh_pkg::LEN_PORT_W-1:0] len_r, len_nxt;
  logic [1:0]  lane_sel_r, lane_sel_nxt;
  logic        last_r, last_nxt;
  logic [63:0] lane_r [4];
  logic [63:0] lane_nxt [4];
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_hash_r, out_hash_nxt;

  logic         fm;
  logic [63:0]  mul_a;
  fmh_pkg::kc_t mul_k;
  logic         mul_fold;
  logic [63:0]  mul_r;
  logic         take;
  logic         finish;
  logic [63:0]  lane_x;

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  assign fm     = (mode == fmh_pkg::MODE_FOLD_ALL) || (mode == fmh_pkg::MODE_FOLD_FINAL);
  assign lane_x = lane_r[0] ^ lane_r[1] ^ lane_r[2] ^ lane_r[3];

  // finalizer xor-shift after each multiply
  function automatic logic [63:0] fin_shift(input logic [63:0] v, input logic [2:0] step);
    logic [63:0] s;
    unique case (step)
      3'd0:    s = v ^ (v >> 29);
      3'd1:    s = v ^ (v >> 31);
      3'd2:    s = v ^ (v >> 37);
      default: s = v ^ (v >> 41);
    endcase
    return s;
  endfunction

  // multiplier operand select
  always_comb begin
    mul_a    = acc_r;
    mul_k    = fmh_pkg::K_0;
    mul_fold = 1'b0;
    unique case (seq_r)
      SEQ_START: begin
        if (step_r == 3'd0) begin
          mul_a = {{(64 - fmh_pkg::LEN_PORT_W){1'b0}}, len_r};
        end else begin
          mul_k = fmh_pkg::kc_t'(step_r[1:0] - 2'd1);
        end
      end
      SEQ_WORD: begin
        mul_a    = lane_r[lane_sel_r] ^ data_r;
        mul_fold = (mode == fmh_pkg::MODE_FOLD_ALL);
      end
      default: begin
        mul_fold = fm;
        unique case (step_r)
          3'd1:    mul_k = fmh_pkg::K_1;
          3'd2:    mul_k = fmh_pkg::K_2;
          default: mul_k = fmh_pkg::K_0;
        endcase
      end
    endcase
  end

  fmh_mul u_mul (
    .clk   (clk),
    .a     (mul_a),
    .k_sel (mul_k),
    .fold  (mul_fold),
    .r     (mul_r)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    seq_nxt       = seq_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    data_nxt      = data_r;
    len_nxt       = len_r;
    lane_sel_nxt  = lane_sel_r;
    last_nxt      = last_r;
    lane_nxt      = lane_r;
    out_valid_nxt = out_valid_r;
    out_hash_nxt  = out_hash_r;
    pop           = 1'b0;
    take          = 1'b0;
    finish        = 1'b0;

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        take = 1'b1;
      end
      S_MUL: begin
        state_nxt = S_WB;
      end
      S_WB: begin
        unique case (seq_r)
          SEQ_START: begin
            if (step_r == 3'd0) begin
              acc_nxt   = data_r ^ mul_r;
              step_nxt  = 3'd1;
              state_nxt = S_MUL;
            end else begin
              lane_nxt[2'(step_r - 3'd1)] = mul_r;
              if (step_r == 3'd4) begin
                finish = 1'b1;
              end else begin
                step_nxt  = step_r + 3'd1;
                state_nxt = S_MUL;
              end
            end
          end
          SEQ_WORD: begin
            lane_nxt[lane_sel_r] = mul_r;
            finish               = 1'b1;
          end
          default: begin
            acc_nxt = fin_shift(mul_r, step_r);
            if (step_r == 3'd3) begin
              state_nxt = S_OUT;
            end else begin
              step_nxt  = step_r + 3'd1;
              state_nxt = S_MUL;
            end
          end
        endcase
        if (finish) begin
          if (last_r) begin
            state_nxt = S_FOLD;
          end else begin
            take = 1'b1;
          end
        end
      end
      S_FOLD: begin
        seq_nxt   = SEQ_FINAL;
        state_nxt = S_MUL;
        if (fm) begin
          acc_nxt  = lane_x;
          step_nxt = 3'd0;
        end else begin
          acc_nxt  = lane_x ^ (lane_x >> 29);
          step_nxt = 3'd1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = acc_r;
          take          = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // fetch the next command from the queue
    if (take) begin
      if (q_valid) begin
        pop          = 1'b1;
        seq_nxt      = head.is_start ? SEQ_START : SEQ_WORD;
        step_nxt     = 3'd0;
        data_nxt     = head.data;
        len_nxt      = head.len;
        lane_sel_nxt = head.lane;
        last_nxt     = head.last;
        state_nxt    = S_MUL;
      end else begin
        state_nxt = S_IDLE;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seq_r       <= SEQ_START;
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seq_r       <= seq_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    data_r     <= data_nxt;
    len_r      <= len_nxt;
    lane_sel_r <= lane_sel_nxt;
    last_r     <= last_nxt;
    lane_r     <= lane_nxt;
    out_hash_r <= out_hash_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/four_lane_multiply_hash64.sv =====
// top level of the four-lane multiply hash: mode register, front, queue and back
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid/in_ready, in_first, in_seed,            | request in
//           | in_total_length, in_data_word                    |
//   out     | out_valid/out_ready, out_hash_value              | request out
//   cfg     | cfg_we, cfg_wdata (mix_mode)                     | write only
//
// Each data word makes one pass through the shared multiplier in the back end
// (partial products, then sum). A start request takes five multiplies; the
// finalizer takes a lane fold and three or four multiplies, then loads the
// output register.
// The front takes a request every cycle while the 2-entry command queue has room.
// Reset is synchronous and active low; the queue comes up empty and the block idle.
// A stalled result waits in the output register; the back end waits behind it.
`timescale 1ns / 1ps
`default_nettype none

module four_lane_multiply_hash64 #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        in_first,
  input  wire logic [63:0] in_seed,
  input  wire logic [31:0] in_total_length,
  input  wire logic [63:0] in_data_word,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [63:0] out_hash_value,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata
);

  logic [1:0]    mix_mode_r, mix_mode_nxt;
  logic          q_full;
  logic          q_valid;
  logic          push;
  logic          pop;
  fmh_pkg::cmd_t push_cmd;
  fmh_pkg::cmd_t head;

  // mode register
  assign mix_mode_nxt = cfg_we ? cfg_wdata : mix_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_mode_r <= fmh_pkg::MODE_PLAIN;
    end else begin
      mix_mode_r <= mix_mode_nxt;
    end
  end

  // request intake
  fmh_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_first        (in_first),
    .in_seed         (in_seed),
    .in_total_length (in_total_length),
    .in_data_word    (in_data_word),
    .q_full          (q_full),
    .push            (push),
    .cmd             (push_cmd)
  );

  // command queue
  fmh_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .head     (head)
  );

  // lane engine and finalizer
  fmh_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .mode           (mix_mode_r),
    .q_valid        (q_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/fmh_checker.sv =====
// port-level checks for the four-lane multiply hash, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module fmh_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_hash_value
);

  // no result right after reset
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // queue is empty after reset so requests are taken
  a_reset_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // a result on the port carries known bits
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_hash_value))
    else $error("result carries unknown bits");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hash_value))
    else $error("stalled result dropped or changed");

  // ready drops only after a request has been taken
  a_in_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && !in_valid |=> in_ready)
    else $error("input ready dropped with no request taken");

endmodule

bind four_lane_multiply_hash64 fmh_checker u_fmh_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_hash_value (out_hash_value)
);

`default_nettype wire
